// ----- hdl/msss_pkg.sv -----
// Shared types, constants and reset tables of the servo sweep scheduler.
// Depends on nothing; every other file in hdl imports it.
package msss_pkg;

   // default configuration of the top level
   localparam int unsigned CHANNELS_DEF           = 24;
   localparam int unsigned CHANNELS_PER_BOARD_DEF = 16;
   localparam int unsigned ANGLE_SPAN_DEF         = 180;

   // field widths
   localparam int unsigned ANGLE_W  = 8;
   localparam int unsigned DUTY_W   = 12;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned STEP_W   = 2;
   localparam int unsigned CHAN_W   = 5;
   localparam int unsigned BCH_W    = 4;
   localparam int unsigned ADDR_W   = 4;
   localparam int unsigned DATA_W   = 32;

   // duty scaling: quotient by reciprocal, magnitudes stay below 2^MAG_W
   localparam int unsigned MAG_W     = 20;
   localparam int unsigned DIV_SHIFT = 20;

   localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_LOAD = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_MIN_ANGLE = 2'd0,
      REG_MAX_ANGLE = 2'd1,
      REG_DUTY_LOW  = 2'd2,
      REG_DUTY_HIGH = 2'd3
   } reg_idx_type;

   localparam logic signed [STEP_W-1:0] STEP_PLUS  = 2'sb01;
   localparam logic signed [STEP_W-1:0] STEP_MINUS = 2'sb11;
   localparam logic signed [STEP_W-1:0] STEP_BAD   = 2'sb10;

   // register reset values
   localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST = 8'd30;
   localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST = 8'd150;
   localparam logic [DUTY_W-1:0]  DUTY_LOW_RST  = 12'd90;
   localparam logic [DUTY_W-1:0]  DUTY_HIGH_RST = 12'd500;

   // channel table reset values
   localparam logic [ANGLE_W-1:0]  ANGLE_RST      = 8'd90;
   localparam logic [ANGLE_W-1:0]  ANGLE_RST_MID  = 8'd135;
   localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd100;
   localparam logic [PERIOD_W-1:0] PERIOD_RST_FST = 16'd10;
   localparam logic [PERIOD_W-1:0] PERIOD_RST_MED = 16'd50;
   localparam int unsigned MID_FIRST  = 8;
   localparam int unsigned MED_FIRST  = 12;
   localparam int unsigned MID_LAST   = 15;

   typedef struct packed {
      logic [ANGLE_W-1:0] min_angle;
      logic [ANGLE_W-1:0] max_angle;
      logic [DUTY_W-1:0]  duty_low;
      logic [DUTY_W-1:0]  duty_high;
   } cfg_type;

   typedef struct packed {
      logic start_tick;
      logic load_entry;
      logic check;
      logic next_chan;
      logic push;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic fire;
      logic last_chan;
      logic pend_valid;
      logic out_free;
   } sts_type;

   function automatic logic [ANGLE_W-1:0] reset_angle(input int unsigned c);
      if (c >= MID_FIRST && c <= MID_LAST) return ANGLE_RST_MID;
      return ANGLE_RST;
   endfunction

   function automatic logic [PERIOD_W-1:0] reset_period(input int unsigned c);
      if (c >= MID_FIRST && c < MED_FIRST) return PERIOD_RST_FST;
      if (c >= MED_FIRST && c <= MID_LAST) return PERIOD_RST_MED;
      return PERIOD_RST;
   endfunction

endpackage

// ----- hdl/msss_regs.sv -----
// Configuration register file behind the APB-style port.
// Depends on msss_pkg.
module msss_regs
   import msss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   logic    wr_en;

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_angle <= MIN_ANGLE_RST;
         cfg_ff.max_angle <= MAX_ANGLE_RST;
         cfg_ff.duty_low  <= DUTY_LOW_RST;
         cfg_ff.duty_high <= DUTY_HIGH_RST;
      end else if (wr_en) begin
         case (paddr[ADDR_W-1:2])
            REG_MIN_ANGLE: cfg_ff.min_angle <= pwdata[ANGLE_W-1:0];
            REG_MAX_ANGLE: cfg_ff.max_angle <= pwdata[ANGLE_W-1:0];
            REG_DUTY_LOW:  cfg_ff.duty_low  <= pwdata[DUTY_W-1:0];
            REG_DUTY_HIGH: cfg_ff.duty_high <= pwdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[ADDR_W-1:2])
         REG_MIN_ANGLE: prdata = DATA_W'(cfg_ff.min_angle);
         REG_MAX_ANGLE: prdata = DATA_W'(cfg_ff.max_angle);
         REG_DUTY_LOW:  prdata = DATA_W'(cfg_ff.duty_low);
         REG_DUTY_HIGH: prdata = DATA_W'(cfg_ff.duty_high);
         default:       prdata = '0;
      endcase
   end

endmodule

// ----- hdl/msss_ctrl.sv -----
// Sequencer of the scheduler: accepts items, walks channels, paces the scaling.
// Depends on msss_pkg; drives the datapath through cmd_type, reads sts_type.
module msss_ctrl
   import msss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_operation,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL1,
      ST_MUL2,
      ST_FINISH,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_LOAD) begin
                  cmd.load_entry = 1'b1;
               end else begin
                  cmd.start_tick = 1'b1;
                  state_in       = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (sts.fire) begin
               state_in = ST_MUL1;
            end else if (sts.last_chan) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.next_chan = 1'b1;
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_FINISH;
         ST_FINISH: begin
            // hold until the older pending result can move on
            if (!sts.pend_valid || sts.out_free) begin
               cmd.push = 1'b1;
               if (sts.last_chan) begin
                  state_in = ST_FLUSH;
               end else begin
                  cmd.next_chan = 1'b1;
                  state_in      = ST_CHECK;
               end
            end
         end
         ST_FLUSH: begin
            if (!sts.pend_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/msss_datapath.sv -----
// Channel table, due check, sweep update, duty scaling and result registers.
// Depends on msss_pkg; commanded by msss_ctrl.
module msss_datapath
   import msss_pkg::*;
#(
   parameter int unsigned CHANNELS           = CHANNELS_DEF,
   parameter int unsigned CHANNELS_PER_BOARD = CHANNELS_PER_BOARD_DEF,
   parameter int unsigned ANGLE_SPAN         = ANGLE_SPAN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   input  cfg_type                    cfg,
   input  logic [TIME_W-1:0]          req_now_ms,
   input  logic [CHAN_W-1:0]          req_channel,
   input  logic [ANGLE_W-1:0]         req_position,
   input  logic signed [STEP_W-1:0]   req_step,
   input  logic [PERIOD_W-1:0]        req_period_ms,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_board,
   output logic [BCH_W-1:0]           rsp_board_channel,
   output logic [DUTY_W-1:0]          rsp_duty_ticks,
   output logic                       rsp_last
);

   localparam int unsigned IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned RECIP   = (1 << DIV_SHIFT) / ANGLE_SPAN;
   localparam int unsigned RECIP_W = DIV_SHIFT + 1;
   localparam int unsigned PROD_W  = ANGLE_W + DUTY_W + 2;
   localparam int unsigned RAW_W   = MAG_W + RECIP_W;
   localparam int unsigned QW      = RAW_W - DIV_SHIFT;
   localparam int unsigned BACK_W  = QW + ANGLE_W;
   localparam int unsigned VW      = QW + 2;
   localparam int unsigned SA_W    = ANGLE_W + 2;

   // channel table
   logic [ANGLE_W-1:0]        angle_ff  [CHANNELS];
   logic signed [STEP_W-1:0]  step_ff   [CHANNELS];
   logic [PERIOD_W-1:0]       period_ff [CHANNELS];
   logic [TIME_W-1:0]         last_ff   [CHANNELS];

   // walk state
   logic [IDX_W-1:0]  idx_ff;
   logic              brd_ff;
   logic [BCH_W-1:0]  bch_ff;
   logic [TIME_W-1:0] now_ff;

   logic [ANGLE_W-1:0]       cur_angle;
   logic signed [STEP_W-1:0] cur_step;
   logic [PERIOD_W-1:0]      cur_period;
   logic [TIME_W-1:0]        cur_last;
   logic [TIME_W-1:0]        elapsed;
   logic                     fire;
   logic                     last_chan;

   logic signed [SA_W-1:0]   nx;
   logic signed [SA_W-1:0]   na;
   logic signed [STEP_W-1:0] new_step;
   logic [ANGLE_W-1:0]       new_angle;
   logic                     reverse;

   logic                     load_ok;
   logic [IDX_W-1:0]         load_idx;
   logic [ANGLE_W-1:0]       load_pos;
   logic signed [STEP_W-1:0] load_step;

   // scaling pipeline
   logic signed [DUTY_W:0]   span;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic [PROD_W-1:0]        mag_full;
   logic [MAG_W-1:0]         mag_in, mag_ff;
   logic [RAW_W-1:0]         raw_in, raw_ff;
   logic                     neg_ff, neg_q_ff;
   logic [QW-1:0]            qest;
   logic [BACK_W-1:0]        back;
   logic [BACK_W-1:0]        rem;
   logic [QW-1:0]            q_in, q_ff;
   logic signed [VW-1:0]     lo_s, q_s, v;
   logic [DUTY_W-1:0]        duty;

   // result registers
   logic              pend_valid_ff;
   logic              pend_board_ff;
   logic [BCH_W-1:0]  pend_bch_ff;
   logic [DUTY_W-1:0] pend_duty_ff;
   logic              out_valid_ff;
   logic              out_board_ff;
   logic [BCH_W-1:0]  out_bch_ff;
   logic [DUTY_W-1:0] out_duty_ff;
   logic              out_last_ff;
   logic              out_free;

   assign cur_angle  = angle_ff[idx_ff];
   assign cur_step   = step_ff[idx_ff];
   assign cur_period = period_ff[idx_ff];
   assign cur_last   = last_ff[idx_ff];
   assign elapsed    = now_ff - cur_last;
   assign fire       = elapsed >= TIME_W'(cur_period);
   assign last_chan  = idx_ff == IDX_W'(CHANNELS - 1);

   // sweep: reverse at the limits, then clamp to the span
   always_comb begin
      nx      = $signed({2'b00, cur_angle}) + SA_W'(cur_step);
      reverse = (nx > $signed({2'b00, cfg.max_angle})) ||
                (nx < $signed({2'b00, cfg.min_angle}));
      new_step = reverse ? -cur_step : cur_step;
      na       = $signed({2'b00, cur_angle}) + SA_W'(new_step);
      if (na < 0) begin
         new_angle = '0;
      end else if (na > $signed(SA_W'(ANGLE_SPAN))) begin
         new_angle = ANGLE_W'(ANGLE_SPAN);
      end else begin
         new_angle = na[ANGLE_W-1:0];
      end
   end

   // load: drop out-of-range channels, saturate position and step
   assign load_ok   = {1'b0, req_channel} < (CHAN_W + 1)'(CHANNELS);
   assign load_idx  = req_channel[IDX_W-1:0];
   assign load_pos  = (req_position > ANGLE_W'(ANGLE_SPAN)) ? ANGLE_W'(ANGLE_SPAN)
                                                            : req_position;
   assign load_step = (req_step == STEP_BAD) ? STEP_MINUS : req_step;

   // the entry is updated only when its result is pushed, so the angle
   // feeding the scaling pipeline holds while the walk waits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            angle_ff[c]  <= reset_angle(c);
            step_ff[c]   <= STEP_PLUS;
            period_ff[c] <= reset_period(c);
            last_ff[c]   <= '0;
         end
      end else if (cmd.load_entry && load_ok) begin
         angle_ff[load_idx]  <= load_pos;
         step_ff[load_idx]   <= load_step;
         period_ff[load_idx] <= req_period_ms;
      end else if (cmd.push) begin
         angle_ff[idx_ff] <= new_angle;
         step_ff[idx_ff]  <= new_step;
         last_ff[idx_ff]  <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         brd_ff <= 1'b0;
         bch_ff <= '0;
      end else if (cmd.start_tick) begin
         idx_ff <= '0;
         brd_ff <= 1'b0;
         bch_ff <= '0;
      end else if (cmd.next_chan) begin
         idx_ff <= idx_ff + 1'b1;
         if (bch_ff == BCH_W'(CHANNELS_PER_BOARD - 1)) begin
            bch_ff <= '0;
            brd_ff <= ~brd_ff;
         end else begin
            bch_ff <= bch_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_tick) begin
         now_ff <= req_now_ms;
      end
   end

   // duty = low + trunc(angle * (high - low) / span); quotient of the magnitude
   // by reciprocal with one correction step
   always_comb begin
      span     = $signed({1'b0, cfg.duty_high}) - $signed({1'b0, cfg.duty_low});
      prod_in  = PROD_W'($signed({1'b0, cur_angle})) * PROD_W'(span);
      mag_full = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      mag_in   = mag_full[MAG_W-1:0];
      raw_in   = RAW_W'(mag_in) * RAW_W'(RECIP);
      qest     = raw_ff[RAW_W-1:DIV_SHIFT];
      back     = BACK_W'(qest) * BACK_W'(ANGLE_SPAN);
      rem      = BACK_W'(mag_ff) - back;
      q_in     = qest + QW'(rem >= BACK_W'(ANGLE_SPAN));
      lo_s     = $signed(VW'(cfg.duty_low));
      q_s      = $signed(VW'(q_ff));
      v        = neg_q_ff ? (lo_s - q_s) : (lo_s + q_s);
      if (v < 0) begin
         duty = '0;
      end else if (v > $signed(VW'(DUTY_MAX))) begin
         duty = DUTY_MAX;
      end else begin
         duty = v[DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mag_ff   <= mag_in;
      raw_ff   <= raw_in;
      neg_ff   <= prod_ff[PROD_W-1];
      q_ff     <= q_in;
      neg_q_ff <= neg_ff;
   end

   // one result is held back so the final one of a tick can be marked
   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.push) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if ((cmd.push && pend_valid_ff) || cmd.flush) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         pend_board_ff <= brd_ff;
         pend_bch_ff   <= bch_ff;
         pend_duty_ff  <= duty;
      end
      if ((cmd.push && pend_valid_ff) || cmd.flush) begin
         out_board_ff <= pend_board_ff;
         out_bch_ff   <= pend_bch_ff;
         out_duty_ff  <= pend_duty_ff;
         out_last_ff  <= cmd.flush;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_board         = out_board_ff;
   assign rsp_board_channel = out_bch_ff;
   assign rsp_duty_ticks    = out_duty_ff;
   assign rsp_last          = out_last_ff;

   assign sts.fire       = fire;
   assign sts.last_chan  = last_chan;
   assign sts.pend_valid = pend_valid_ff;
   assign sts.out_free   = out_free;

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push && pend_valid_ff |-> out_free)
      else $error("pending result pushed into a full output register");

   a_flush_pend: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> pend_valid_ff)
      else $error("flush without a pending result");

   a_step_code: assert property (@(posedge clock) disable iff (reset)
      cmd.check |-> cur_step != STEP_BAD)
      else $error("channel table holds the unused step pattern");

endmodule

// ----- hdl/multi_servo_sweep_scheduler.sv -----
// Top level of the multichannel servo sweep scheduler.
// Depends on msss_pkg, msss_regs, msss_ctrl and msss_datapath.
//
// Usage:
//  - req_* channel (valid/ready): operation selects a load (write angle, step
//    and period of one channel, gives no result) or a tick (now_ms, visit every
//    channel in ascending order).
//  - rsp_* channel (valid/ready): one transfer per channel whose period has
//    elapsed on a tick: board, board_channel, duty_ticks from the angle before
//    the step; last marks the final transfer of the tick.
//  - APB-style port: min_angle, max_angle, duty_low, duty_high at 0x0, 0x4,
//    0x8, 0xC; write only while the block is idle. pready is tied high.
// Walk: a tick visits every channel in turn; each channel that fires passes
//  through the duty scaling pipeline of two multiplier stages and one correction
//  stage, and the final result is handed out at the end. A new item is taken
//  only when the previous tick has finished its walk.
// Results are held in a pending register and an output register, so the
//  receiver may stall freely; the walk holds when both are occupied and rsp_ready is low.
// Reset (synchronous): registers and the channel table return to their
//  power-on values, both result registers empty.
module multi_servo_sweep_scheduler
   import msss_pkg::*;
#(
   parameter int unsigned CHANNELS           = CHANNELS_DEF,
   parameter int unsigned CHANNELS_PER_BOARD = CHANNELS_PER_BOARD_DEF,
   parameter int unsigned ANGLE_SPAN         = ANGLE_SPAN_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic [TIME_W-1:0]        req_now_ms,
   input  logic [CHAN_W-1:0]        req_channel,
   input  logic [ANGLE_W-1:0]       req_position,
   input  logic signed [STEP_W-1:0] req_step,
   input  logic [PERIOD_W-1:0]      req_period_ms,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_board,
   output logic [BCH_W-1:0]         rsp_board_channel,
   output logic [DUTY_W-1:0]        rsp_duty_ticks,
   output logic                     rsp_last,
   // configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [ADDR_W-1:0]        paddr,
   input  logic [DATA_W-1:0]        pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   // register file: limits and duty endpoints
   msss_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: accept items, advance the walk, hold on a full output
   msss_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   // channel table, scaling and result registers
   msss_datapath #(
      .CHANNELS           (CHANNELS),
      .CHANNELS_PER_BOARD (CHANNELS_PER_BOARD),
      .ANGLE_SPAN         (ANGLE_SPAN)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .cfg               (cfg),
      .req_now_ms        (req_now_ms),
      .req_channel       (req_channel),
      .req_position      (req_position),
      .req_step          (req_step),
      .req_period_ms     (req_period_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_board         (rsp_board),
      .rsp_board_channel (rsp_board_channel),
      .rsp_duty_ticks    (rsp_duty_ticks),
      .rsp_last          (rsp_last)
   );

endmodule

// ----- tb/multi_servo_sweep_scheduler_tb.sv -----
// Self-checking testbench of the multichannel servo sweep scheduler.
// Depends on msss_pkg and multi_servo_sweep_scheduler; drives both valid/ready
// channels and the APB-style port, predicts result transfers or takes typed expectations.
module multi_servo_sweep_scheduler_tb;
   import msss_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // wait that covers the take, the walk of 24 channels, the scaling of each firing channel and the flush
   localparam int SETTLE_CYCLES = 120;
   localparam int LONG_HOLD     = 600;
   localparam int SPAN          = 180;
   localparam int PHASE_ITEMS   = 75;
   localparam int NOT_TYPED     = -1;

   typedef enum logic { ROW_ITEM, ROW_REG } row_kind_type;

   // one line of the directed stimulus table
   typedef struct packed {
      row_kind_type        kind;
      op_type              op;
      logic [TIME_W-1:0]   now_ms;
      logic [CHAN_W-1:0]   channel;
      logic [ANGLE_W-1:0]  position;
      logic [STEP_W-1:0]   step;
      logic [PERIOD_W-1:0] period_ms;
      logic signed [7:0]   typed_count;   // NOT_TYPED: use the predictor
      logic [CHAN_W-1:0]   typed_first;
      logic [DUTY_W-1:0]   typed_duty;
      reg_idx_type         reg_idx;
      logic [DATA_W-1:0]   reg_value;
   } plan_row_type;

   // one pulse update as it leaves the block
   typedef struct packed {
      logic              board;
      logic [BCH_W-1:0]  board_channel;
      logic [DUTY_W-1:0] duty_ticks;
      logic              last;
   } pulse_type;

   logic clock = 1'b0;
   logic reset;

   logic                     req_valid;
   logic                     req_ready;
   logic                     req_operation;
   logic [TIME_W-1:0]        req_now_ms;
   logic [CHAN_W-1:0]        req_channel;
   logic [ANGLE_W-1:0]       req_position;
   logic signed [STEP_W-1:0] req_step;
   logic [PERIOD_W-1:0]      req_period_ms;

   logic                     rsp_valid;
   logic                     rsp_ready;
   logic                     rsp_board;
   logic [BCH_W-1:0]         rsp_board_channel;
   logic [DUTY_W-1:0]        rsp_duty_ticks;
   logic                     rsp_last;

   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [ADDR_W-1:0]        paddr;
   logic [DATA_W-1:0]        pwdata;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;

   // predictor copy of the registers and the channel table
   logic [ANGLE_W-1:0]       sweep_min;
   logic [ANGLE_W-1:0]       sweep_max;
   logic [DUTY_W-1:0]        duty_at_zero;
   logic [DUTY_W-1:0]        duty_at_span;
   logic [ANGLE_W-1:0]       angle_tbl  [CHANNELS_DEF];
   logic signed [STEP_W-1:0] step_tbl   [CHANNELS_DEF];
   logic [PERIOD_W-1:0]      period_tbl [CHANNELS_DEF];
   logic [TIME_W-1:0]        stamp_tbl  [CHANNELS_DEF];

   pulse_type    awaited_pulses[$];   // pulse updates still owed by the block
   pulse_type    tick_pulses[$];      // what the latest tick fired
   plan_row_type directed_plan[$];

   int  error_count      = 0;   // result mismatches, counted by the receiver
   int  reg_error_count  = 0;   // read-back mismatches, counted by the sender
   int  long_holds_asked = 0;   // raised by the sender only

   always #5 clock = ~clock;

   multi_servo_sweep_scheduler uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_now_ms        (req_now_ms),
      .req_channel       (req_channel),
      .req_position      (req_position),
      .req_step          (req_step),
      .req_period_ms     (req_period_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_board         (rsp_board),
      .rsp_board_channel (rsp_board_channel),
      .rsp_duty_ticks    (rsp_duty_ticks),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Power-on contents: mid channels start at 135 degrees, fast and medium
   // groups have short periods, the rest sit at 90 degrees every 100 ms.
   function automatic void reset_sweep_state();
      sweep_min    = 8'd30;
      sweep_max    = 8'd150;
      duty_at_zero = 12'd90;
      duty_at_span = 12'd500;
      for (int c = 0; c < CHANNELS_DEF; c++) begin
         angle_tbl[c] = (c >= 8 && c <= 15) ? 8'd135 : 8'd90;
         step_tbl[c]  = 2'sb01;
         if (c >= 8 && c <= 11)       period_tbl[c] = 16'd10;
         else if (c >= 12 && c <= 15) period_tbl[c] = 16'd50;
         else                         period_tbl[c] = 16'd100;
         stamp_tbl[c] = '0;
      end
   endfunction

   function automatic logic [DATA_W-1:0] register_mask(reg_idx_type idx);
      if (idx == REG_MIN_ANGLE || idx == REG_MAX_ANGLE) return 32'h0000_00FF;
      return 32'h0000_0FFF;
   endfunction

   function automatic void apply_register(reg_idx_type idx, logic [DATA_W-1:0] value);
      case (idx)
         REG_MIN_ANGLE: sweep_min    = value[ANGLE_W-1:0];
         REG_MAX_ANGLE: sweep_max    = value[ANGLE_W-1:0];
         REG_DUTY_LOW:  duty_at_zero = value[DUTY_W-1:0];
         REG_DUTY_HIGH: duty_at_span = value[DUTY_W-1:0];
         default: ;
      endcase
   endfunction

   // Linear map of 0..SPAN onto the duty limits; signed division truncates
   // toward zero, so reversed limits still land between the two.
   function automatic logic [DUTY_W-1:0] duty_for_angle(logic [ANGLE_W-1:0] ang);
      int lo;
      int span;
      int v;
      lo   = int'(duty_at_zero);
      span = int'(duty_at_span) - lo;
      v    = lo + (int'(ang) * span) / SPAN;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[DUTY_W-1:0];
   endfunction

   function automatic void load_channel(logic [CHAN_W-1:0] ch, logic [ANGLE_W-1:0] pos,
                                        logic [STEP_W-1:0] stp, logic [PERIOD_W-1:0] per);
      // drop loads aimed beyond the table
      if (ch >= CHANNELS_DEF) return;
      angle_tbl[ch]  = (pos > SPAN) ? SPAN[ANGLE_W-1:0] : pos;
      if (stp == STEP_PLUS)   step_tbl[ch] = STEP_PLUS;
      else if (stp == 2'b00)  step_tbl[ch] = 2'sb00;
      else                    step_tbl[ch] = STEP_MINUS;   // minus two saturates
      period_tbl[ch] = per;
   endfunction

   function automatic void sweep_tick(logic [TIME_W-1:0] now);
      pulse_type         r;
      logic [TIME_W-1:0] elapsed;
      int                a;
      int                s;
      tick_pulses.delete();
      for (int c = 0; c < CHANNELS_DEF; c++) begin
         elapsed = now - stamp_tbl[c];   // wraps modulo 2^32
         if (elapsed < {16'd0, period_tbl[c]}) continue;
         stamp_tbl[c]    = now;
         r.board         = ((c / CHANNELS_PER_BOARD_DEF) % 2) != 0;
         r.board_channel = BCH_W'(c % CHANNELS_PER_BOARD_DEF);
         r.duty_ticks    = duty_for_angle(angle_tbl[c]);
         r.last          = 1'b0;
         tick_pulses.push_back(r);
         a = angle_tbl[c];
         s = step_tbl[c];
         if (a + s > int'(sweep_max) || a + s < int'(sweep_min)) s = -s;
         a = a + s;
         if (a < 0) a = 0;
         if (a > SPAN) a = SPAN;
         angle_tbl[c] = a[ANGLE_W-1:0];
         step_tbl[c]  = s[STEP_W-1:0];
      end
      if (tick_pulses.size() > 0) begin
         r      = tick_pulses.pop_back();
         r.last = 1'b1;
         tick_pulses.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------

   function automatic void plan_item(op_type op, logic [TIME_W-1:0] now,
                                     logic [CHAN_W-1:0] ch, logic [ANGLE_W-1:0] pos,
                                     logic [STEP_W-1:0] stp, logic [PERIOD_W-1:0] per,
                                     int typed_count, int typed_first, int typed_duty);
      plan_row_type row;
      row             = '0;
      row.kind        = ROW_ITEM;
      row.op          = op;
      row.now_ms      = now;
      row.channel     = ch;
      row.position    = pos;
      row.step        = stp;
      row.period_ms   = per;
      row.typed_count = typed_count[7:0];
      row.typed_first = typed_first[CHAN_W-1:0];
      row.typed_duty  = typed_duty[DUTY_W-1:0];
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_register(reg_idx_type idx, logic [DATA_W-1:0] value);
      plan_row_type row;
      row           = '0;
      row.kind      = ROW_REG;
      row.reg_idx   = idx;
      row.reg_value = value;
      directed_plan.push_back(row);
   endfunction

   function automatic void build_directed_plan();
      // straight after reset nothing has had time to elapse
      plan_item(OP_TICK, 32'd0,  5'd0, 8'd0, 2'b00, 16'd0, 0, 0, 0);
      // the fast group (8..11) fires at 135 degrees: 90 + 135*410/180
      plan_item(OP_TICK, 32'd10, 5'd0, 8'd0, 2'b00, 16'd0, 4, 8, 397);
      plan_item(OP_TICK, 32'd10, 5'd0, 8'd0, 2'b00, 16'd0, 0, 0, 0);
      // every channel due at once
      plan_item(OP_TICK, 32'd100, 5'd0, 8'd0, 2'b00, 16'd0, NOT_TYPED, 0, 0);
      // widest duty span and sweep limits
      plan_register(REG_DUTY_LOW,  32'd0);
      plan_register(REG_DUTY_HIGH, 32'd4095);
      plan_register(REG_MIN_ANGLE, 32'd0);
      plan_register(REG_MAX_ANGLE, 32'd180);
      // oversized position saturates; zero period fires on every tick
      plan_item(OP_LOAD, 32'hFFFF_FFFF, 5'd0, 8'd255, 2'b00, 16'd0, 0, 0, 0);
      plan_item(OP_TICK, 32'd101, 5'd31, 8'd255, 2'b11, 16'hFFFF, 1, 0, 4095);
      // unused step pattern turns into minus one
      plan_item(OP_LOAD, 32'd0, 5'd23, 8'd0, STEP_BAD, 16'd0, 0, 0, 0);
      // loads past the table are dropped
      plan_item(OP_LOAD, 32'd0, 5'd24, 8'd7, STEP_PLUS, 16'd0, 0, 0, 0);
      plan_item(OP_LOAD, 32'd0, 5'd31, 8'd7, STEP_PLUS, 16'd0, 0, 0, 0);
      plan_item(OP_TICK, 32'd102, 5'd0, 8'd0, 2'b00, 16'd0, NOT_TYPED, 0, 0);
      // reversed duty limits, truncation toward zero
      plan_register(REG_DUTY_LOW,  32'd4095);
      plan_register(REG_DUTY_HIGH, 32'd0);
      plan_item(OP_LOAD, 32'd0, 5'd1, 8'd1, STEP_PLUS, 16'd0, 0, 0, 0);
      plan_item(OP_TICK, 32'd103, 5'd0, 8'd0, 2'b00, 16'd0, NOT_TYPED, 0, 0);
      // limits out of order, then beyond the span
      plan_register(REG_MIN_ANGLE, 32'd150);
      plan_register(REG_MAX_ANGLE, 32'd30);
      plan_item(OP_TICK, 32'd104, 5'd0, 8'd0, 2'b00, 16'd0, NOT_TYPED, 0, 0);
      plan_register(REG_MIN_ANGLE, 32'd255);
      plan_register(REG_MAX_ANGLE, 32'd255);
      plan_item(OP_LOAD, 32'd0, 5'd5, 8'd180, STEP_PLUS, 16'd0, 0, 0, 0);
      plan_item(OP_TICK, 32'd105, 5'd0, 8'd0, 2'b00, 16'd0, NOT_TYPED, 0, 0);
      // top of the time range, then wrap past zero
      plan_item(OP_TICK, 32'hFFFF_FFFF, 5'd0, 8'd0, 2'b00, 16'd0, NOT_TYPED, 0, 0);
      plan_item(OP_TICK, 32'd3, 5'd0, 8'd0, 2'b00, 16'd0, NOT_TYPED, 0, 0);
      // longest period, just elapsed across the wrap
      plan_item(OP_LOAD, 32'd0, 5'd2, 8'd90, STEP_PLUS, 16'hFFFF, 0, 0, 0);
      plan_item(OP_TICK, 32'd65537, 5'd0, 8'd0, 2'b00, 16'd0, NOT_TYPED, 0, 0);
      plan_register(REG_MIN_ANGLE, 32'd30);
      plan_register(REG_MAX_ANGLE, 32'd150);
      plan_register(REG_DUTY_LOW,  32'd90);
      plan_register(REG_DUTY_HIGH, 32'd500);
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Raise valid with the payload and hold until the transfer completes.
   task automatic offer_request(op_type op, logic [TIME_W-1:0] now, logic [CHAN_W-1:0] ch,
                                logic [ANGLE_W-1:0] pos, logic [STEP_W-1:0] stp,
                                logic [PERIOD_W-1:0] per);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_now_ms    <= now;
      req_channel   <= ch;
      req_position  <= pos;
      req_step      <= stp;
      req_period_ms <= per;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Advance the predictor for an accepted item; typed rows supply their own
   // expectation, all others take what the predictor computed.
   task automatic predict_transfer(op_type op, logic [TIME_W-1:0] now,
                                   logic [CHAN_W-1:0] ch, logic [ANGLE_W-1:0] pos,
                                   logic [STEP_W-1:0] stp, logic [PERIOD_W-1:0] per,
                                   int typed_count, int typed_first, int typed_duty);
      pulse_type r;
      int        c;
      tick_pulses.delete();
      if (op == OP_LOAD) load_channel(ch, pos, stp, per);
      else               sweep_tick(now);
      if (typed_count == NOT_TYPED) begin
         foreach (tick_pulses[k]) awaited_pulses.push_back(tick_pulses[k]);
      end else begin
         for (int k = 0; k < typed_count; k++) begin
            c               = typed_first + k;
            r.board         = ((c / CHANNELS_PER_BOARD_DEF) % 2) != 0;
            r.board_channel = BCH_W'(c % CHANNELS_PER_BOARD_DEF);
            r.duty_ticks    = typed_duty[DUTY_W-1:0];
            r.last          = (k == typed_count - 1);
            awaited_pulses.push_back(r);
         end
      end
   endtask

   // Drop valid for a gap; never call with zero cycles.
   task automatic pause_request(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off until every owed pulse has arrived and the walk has surely ended.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_pulses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup and access write, then a read back of the same register.
   task automatic write_register(reg_idx_type idx, logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] want;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      apply_register(idx, value);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      want = value & register_mask(idx);
      if (prdata !== want) begin
         $error("register %s read back: expected %0d, got %0d", idx.name(), want, prdata);
         reg_error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Register settings of each random phase; phase one holds the extremes.
   task automatic configure_phase(int phase);
      logic [DATA_W-1:0] junk;
      junk = (phase == 2) ? $urandom : 32'd0;   // high bits the port must ignore
      case (phase)
         0: begin
            write_register(REG_MIN_ANGLE, $urandom_range(0, 60));
            write_register(REG_MAX_ANGLE, $urandom_range(120, 180));
            write_register(REG_DUTY_LOW,  $urandom_range(50, 200));
            write_register(REG_DUTY_HIGH, $urandom_range(300, 600));
         end
         1: begin
            write_register(REG_MIN_ANGLE, 32'd0);
            write_register(REG_MAX_ANGLE, 32'd180);
            write_register(REG_DUTY_LOW,  32'd0);
            write_register(REG_DUTY_HIGH, 32'd4095);
         end
         2: begin
            write_register(REG_MIN_ANGLE, (junk & ~32'hFF)  | $urandom_range(0, 255));
            write_register(REG_MAX_ANGLE, (junk & ~32'hFF)  | $urandom_range(0, 255));
            write_register(REG_DUTY_LOW,  (junk & ~32'hFFF) | $urandom_range(0, 4095));
            write_register(REG_DUTY_HIGH, (junk & ~32'hFFF) | $urandom_range(0, 4095));
         end
         default: begin
            // reversed duty limits with ordinary sweep limits
            write_register(REG_MIN_ANGLE, $urandom_range(10, 80));
            write_register(REG_MAX_ANGLE, $urandom_range(100, 170));
            write_register(REG_DUTY_LOW,  $urandom_range(2000, 4095));
            write_register(REG_DUTY_HIGH, $urandom_range(0, 1999));
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_pulse();
      pulse_type want;
      if (awaited_pulses.size() == 0) begin
         $error("unexpected transfer: board %0d, board_channel %0d, duty_ticks %0d, last %0d",
                rsp_board, rsp_board_channel, rsp_duty_ticks, rsp_last);
         error_count++;
         return;
      end
      want = awaited_pulses.pop_front();
      compare_field("board",         want.board,         rsp_board);
      compare_field("board_channel", want.board_channel, rsp_board_channel);
      compare_field("duty_ticks",    want.duty_ticks,    rsp_duty_ticks);
      compare_field("last",          want.last,          rsp_last);
   endfunction

   // Receiver: check each completed transfer, then pick the next ready level.
   // The pattern rotates through always ready, coin flip, mostly stalled and
   // a slow toggle; a long hold-off is taken once when the sender asks for it.
   initial begin : receiver
      int hold_left;
      int cyc;
      int holds_taken;
      hold_left   = 0;
      cyc         = 0;
      holds_taken = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_pulse();
         cyc++;
         if (long_holds_asked != holds_taken) begin
            holds_taken = long_holds_asked;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case ((cyc / 97) % 4)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= $urandom_range(0, 1);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ((cyc / 3) % 2) != 0;
            endcase
         end
      end
   end

   // Guard against a hang: far beyond the slowest correct run.
   initial begin : watchdog
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : sender
      plan_row_type        row;
      op_type              op;
      logic [TIME_W-1:0]   now;
      logic [TIME_W-1:0]   tick_time;
      logic [CHAN_W-1:0]   ch;
      logic [ANGLE_W-1:0]  pos;
      logic [STEP_W-1:0]   stp;
      logic [PERIOD_W-1:0] per;
      int                  burst_left;

      // initialise every input before the first edge
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= OP_TICK;
      req_now_ms    <= '0;
      req_channel   <= '0;
      req_position  <= '0;
      req_step      <= '0;
      req_period_ms <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;

      reset_sweep_state();
      build_directed_plan();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table; registers only change with the block idle
      foreach (directed_plan[n]) begin
         row = directed_plan[n];
         if (row.kind == ROW_REG) begin
            drain_results();
            write_register(row.reg_idx, row.reg_value);
         end else begin
            offer_request(row.op, row.now_ms, row.channel, row.position, row.step,
                          row.period_ms);
            predict_transfer(row.op, row.now_ms, row.channel, row.position, row.step,
                             row.period_ms, int'(row.typed_count), int'(row.typed_first),
                             int'(row.typed_duty));
            if ($urandom_range(0, 2) == 0) pause_request($urandom_range(1, 4));
         end
      end

      // random phases: mostly a steadily advancing clock with occasional
      // jumps, loads that retune channels, and some loads past the table
      tick_time = 32'd65600;
      for (int phase = 0; phase < 4; phase++) begin
         drain_results();
         configure_phase(phase);
         // phase one: receiver holds off while the sender never pauses
         if (phase == 1) long_holds_asked++;
         burst_left = $urandom_range(1, 12);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // let the block run dry once mid-phase
            if (phase == 2 && i == PHASE_ITEMS / 2) drain_results();
            ch  = $urandom;
            pos = $urandom;
            stp = $urandom;
            per = $urandom;
            now = $urandom;
            if ($urandom_range(0, 9) < 3) begin
               op = OP_LOAD;
               if ($urandom_range(0, 9) != 0) ch = $urandom_range(0, CHANNELS_DEF - 1);
               if ($urandom_range(0, 4) != 0) pos = $urandom_range(0, SPAN);
               case ($urandom_range(0, 9))
                  0:       ;   // keep the full 16-bit period
                  1, 2:    per = $urandom_range(0, 2000);
                  default: per = $urandom_range(0, 120);
               endcase
            end else begin
               op = OP_TICK;
               if ($urandom_range(0, 9) == 0) tick_time = $urandom;
               else                           tick_time = tick_time + $urandom_range(0, 40);
               now = tick_time;
            end
            offer_request(op, now, ch, pos, stp, per);
            predict_transfer(op, now, ch, pos, stp, per, NOT_TYPED, 0, 0);
            if (phase != 1) begin
               burst_left--;
               if (burst_left == 0) begin
                  pause_request($urandom_range(1, 10));
                  burst_left = $urandom_range(1, 12);
               end
            end
         end
      end

      // wait for the last pulses, then give stray transfers time to show
      drain_results();
      if (error_count == 0 && reg_error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
